FILE: hdl/rsmw_pkg.sv
// Shared types and constants for the ridge single-maximum window block.
`default_nettype none
package rsmw_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MODULUS_BITS = 16;
    localparam int MAX_HEIGHT   = 1024;
    localparam int MIN_DIM      = 3;

    localparam int COL_BITS     = $clog2(MAX_WIDTH);
    localparam int ROW_BITS     = $clog2(MAX_HEIGHT + 1);
    localparam int CELL_BITS    = MODULUS_BITS + 1;

    // fixed field widths of the port words
    localparam int IN_MOD_BITS   = 16;
    localparam int CX_BITS       = 10;
    localparam int CY_BITS       = 10;
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 11;

    localparam logic [CFG_DATA_BITS-1:0] RESET_WIDTH  = CFG_DATA_BITS'(256);
    localparam logic [CFG_DATA_BITS-1:0] RESET_HEIGHT = CFG_DATA_BITS'(256);

    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = CFG_IDX_BITS'(1);

    localparam logic CMD_POINT = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // clockwise neighbor walk
    localparam int RING_SIZE    = 8;
    localparam int RING_TL      = 0;
    localparam int RING_T       = 1;
    localparam int RING_TR      = 2;
    localparam int RING_R       = 3;
    localparam int RING_BR      = 4;
    localparam int RING_B       = 5;
    localparam int RING_BL      = 6;
    localparam int RING_L       = 7;
    localparam int TRANS_TARGET = 2;

    typedef struct packed {
        logic                    present;
        logic [MODULUS_BITS-1:0] modulus;
    } t_cell;

    typedef struct packed {
        logic                   command;
        logic                   point_present;
        logic [IN_MOD_BITS-1:0] point_modulus;
    } t_in_word;

    typedef struct packed {
        logic [CX_BITS-1:0] center_x;
        logic [CY_BITS-1:0] center_y;
        logic               center_present;
        logic               is_single_max;
        logic               last_of_run;
        logic               last_of_frame;
    } t_out_word;

    typedef struct packed {
        t_cell                         center;
        t_cell [RING_SIZE-1:0]         ring;
        logic  [RING_SIZE-1:0]         in_frame;
    } t_nbhd;

    // per-item control carried down the pipeline
    typedef struct packed {
        logic [COL_BITS-1:0] col;
        logic [ROW_BITS-1:0] cy;
        logic                emit1;
        logic                emit2;
        logic                top_in;
        logic                bot_in;
        logic                left_in;
        logic                last_row;
    } t_ctl;

    typedef struct packed {
        t_cell cur;
        logic  up_ok;
        logic  mid_ok;
        t_ctl  ctl;
    } t_s1;

endpackage
`default_nettype wire

FILE: hdl/rsmw_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module rsmw_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: hdl/rsmw_judge.sv
// Transition count and modulus test on one 3x3 neighborhood.
`default_nettype none
module rsmw_judge (
    input  wire rsmw_pkg::t_nbhd i_nbhd,
    output logic                 o_sole_peak
);
    import rsmw_pkg::*;

    logic [RING_SIZE-1:0] pres;
    logic [RING_SIZE-1:0] trans;
    logic [RING_SIZE-1:0] larger;

    always_comb begin
        for (int i = 0; i < RING_SIZE; i++) begin
            pres[i] = i_nbhd.in_frame[i] & i_nbhd.ring[i].present;
        end
        for (int i = 0; i < RING_SIZE; i++) begin
            // present followed by absent, wrapping back to the first
            trans[i]  = pres[i] & ~pres[(i + 1) % RING_SIZE];
            larger[i] = pres[i] & (i_nbhd.center.modulus < i_nbhd.ring[i].modulus);
        end
        o_sole_peak = i_nbhd.center.present && ($countones(trans) == TRANS_TARGET)
                      && (larger == '0);
    end

endmodule
`default_nettype wire

FILE: hdl/ridge_single_max_window.sv
// Single-maximum judge over a raster stream with two line RAMs and a 3x3 window.
// Pipeline: an accepted input word passes stage 1, stage 2 and the output register;
// the second result of a last-column word follows the first out of stage 2.
// Throughput: one input word per cycle unless output back-pressure or a two-result word
// holds stage 2; on the last column of every row after the first the word yields two results.
// Reset: counters to zero, 256x256 frame; line RAM contents are ignored until rows fill.
`default_nettype none
module ridge_single_max_window (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire rsmw_pkg::t_in_word                  i_in,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output rsmw_pkg::t_out_word                      o_out,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [rsmw_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire logic [rsmw_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import rsmw_pkg::*;

    // configuration and counters
    logic [COL_BITS-1:0] r_last_col, n_last_col;
    logic [ROW_BITS-1:0] r_height, n_height;
    logic [COL_BITS-1:0] r_col, n_col;
    logic [ROW_BITS-1:0] r_row, n_row;

    // pipeline
    logic      r_s1_valid, n_s1_valid;
    t_s1       r_s1;
    t_s1       s0_word;
    logic      r_s2_valid, n_s2_valid;
    logic      r_s2_second, n_s2_second;
    t_ctl      r_s2;
    logic      r_out_valid, n_out_valid;
    t_out_word r_out;
    t_out_word res_word;
    t_cell     r_win [3][3];
    t_cell     new_col [3];

    logic cfg_fire, in_fire, s1_adv, s2_done, push, out_free;
    logic sel2, has_res, cur_last, sole_peak;
    t_nbhd nbhd;

    logic [CELL_BITS-1:0] up_rd, mid_rd;
    t_cell up_cell, mid_cell;

    function automatic logic [COL_BITS-1:0] clamp_last_col(logic [CFG_DATA_BITS-1:0] v);
        logic [COL_BITS-1:0] lc;
        if (v < CFG_DATA_BITS'(MIN_DIM)) begin
            lc = COL_BITS'(MIN_DIM - 1);
        end else if (32'(v) > MAX_WIDTH) begin
            lc = COL_BITS'(MAX_WIDTH - 1);
        end else begin
            lc = COL_BITS'(v - CFG_DATA_BITS'(1));
        end
        return lc;
    endfunction

    function automatic logic [ROW_BITS-1:0] clamp_height(logic [CFG_DATA_BITS-1:0] v);
        logic [ROW_BITS-1:0] h;
        if (v < CFG_DATA_BITS'(MIN_DIM)) begin
            h = ROW_BITS'(MIN_DIM);
        end else if (32'(v) > MAX_HEIGHT) begin
            h = ROW_BITS'(MAX_HEIGHT);
        end else begin
            h = ROW_BITS'(v);
        end
        return h;
    endfunction

    // ---------------- handshakes ----------------
    assign o_cfg_ready = i_rst_n && !r_s1_valid && !r_s2_valid && !r_out_valid;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;

    assign out_free = !r_out_valid || i_out_ready;
    assign sel2     = r_s2_second || !r_s2.emit1;
    assign has_res  = r_s2.emit1 || r_s2.emit2;
    assign cur_last = sel2 || !r_s2.emit2;
    assign push     = r_s2_valid && has_res && out_free;
    assign s2_done  = r_s2_valid && (!has_res || (out_free && cur_last));
    assign s1_adv   = r_s1_valid && (!r_s2_valid || s2_done);

    assign o_in_ready = i_rst_n && (!r_s1_valid || s1_adv) && !cfg_fire;
    assign in_fire    = i_in_valid && o_in_ready;

    // ---------------- stage 0: counters and line RAM read ----------------
    always_comb begin
        s0_word.cur.present     = (i_in.command == CMD_POINT) && i_in.point_present
                                  && (r_row != r_height);
        s0_word.cur.modulus     = s0_word.cur.present ?
                                  MODULUS_BITS'(i_in.point_modulus) : '0;
        s0_word.up_ok           = r_row >= ROW_BITS'(2);
        s0_word.mid_ok          = r_row != '0;
        s0_word.ctl.col         = r_col;
        s0_word.ctl.cy          = r_row - ROW_BITS'(1);
        s0_word.ctl.emit1       = (r_row != '0) && (r_col != '0);
        s0_word.ctl.emit2       = (r_row != '0) && (r_col == r_last_col);
        s0_word.ctl.top_in      = r_row >= ROW_BITS'(2);
        s0_word.ctl.bot_in      = r_row != r_height;
        s0_word.ctl.left_in     = r_col >= COL_BITS'(2);
        s0_word.ctl.last_row    = r_row == r_height;
    end

    always_comb begin
        n_last_col = r_last_col;
        n_height   = r_height;
        n_col      = r_col;
        n_row      = r_row;
        if (cfg_fire) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH: begin
                    n_last_col = clamp_last_col(i_cfg_data);
                    n_col      = '0;
                    n_row      = '0;
                end
                REG_IMAGE_HEIGHT: begin
                    n_height = clamp_height(i_cfg_data);
                    n_col    = '0;
                    n_row    = '0;
                end
                default: begin
                end
            endcase
        end else if (in_fire) begin
            if (r_col == r_last_col) begin
                n_col = '0;
                // after the drain row the frame restarts
                n_row = (r_row >= r_height) ? '0 : r_row + ROW_BITS'(1);
            end else begin
                n_col = r_col + COL_BITS'(1);
            end
        end
    end

    // Consecutive words never share a column (width >= 3), so the write-back of
    // one word always lands before the next read of that column.
    rsmw_ram #(.WIDTH(CELL_BITS), .DEPTH(MAX_WIDTH)) u_upper_ram (
        .i_clk     (i_clk),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1.ctl.col),
        .i_wr_data (mid_cell),
        .i_rd_en   (in_fire),
        .i_rd_addr (r_col),
        .o_rd_data (up_rd)
    );

    rsmw_ram #(.WIDTH(CELL_BITS), .DEPTH(MAX_WIDTH)) u_middle_ram (
        .i_clk     (i_clk),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1.ctl.col),
        .i_wr_data (r_s1.cur),
        .i_rd_en   (in_fire),
        .i_rd_addr (r_col),
        .o_rd_data (mid_rd)
    );

    // ---------------- stage 1: mask stale rows, shift window ----------------
    always_comb begin
        up_cell    = r_s1.up_ok  ? t_cell'(up_rd)  : '0;
        mid_cell   = r_s1.mid_ok ? t_cell'(mid_rd) : '0;
        new_col[0] = up_cell;
        new_col[1] = mid_cell;
        new_col[2] = r_s1.cur;
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
                r_win[i][2] <= new_col[i];
            end
            r_s2 <= r_s1.ctl;
        end
        if (in_fire) begin
            r_s1 <= s0_word;
        end
        if (push) begin
            r_out <= res_word;
        end
    end

    // ---------------- stage 2: judge one center a cycle ----------------
    always_comb begin
        nbhd = '0;
        if (sel2) begin
            // last-column center: right column lies outside
            nbhd.center            = r_win[1][2];
            nbhd.ring[RING_TL]     = r_win[0][1];
            nbhd.ring[RING_T]      = r_win[0][2];
            nbhd.ring[RING_B]      = r_win[2][2];
            nbhd.ring[RING_BL]     = r_win[2][1];
            nbhd.ring[RING_L]      = r_win[1][1];
            nbhd.in_frame[RING_TL] = r_s2.top_in;
            nbhd.in_frame[RING_T]  = r_s2.top_in;
            nbhd.in_frame[RING_B]  = r_s2.bot_in;
            nbhd.in_frame[RING_BL] = r_s2.bot_in;
            nbhd.in_frame[RING_L]  = 1'b1;
        end else begin
            nbhd.center            = r_win[1][1];
            nbhd.ring[RING_TL]     = r_win[0][0];
            nbhd.ring[RING_T]      = r_win[0][1];
            nbhd.ring[RING_TR]     = r_win[0][2];
            nbhd.ring[RING_R]      = r_win[1][2];
            nbhd.ring[RING_BR]     = r_win[2][2];
            nbhd.ring[RING_B]      = r_win[2][1];
            nbhd.ring[RING_BL]     = r_win[2][0];
            nbhd.ring[RING_L]      = r_win[1][0];
            nbhd.in_frame[RING_TL] = r_s2.top_in && r_s2.left_in;
            nbhd.in_frame[RING_T]  = r_s2.top_in;
            nbhd.in_frame[RING_TR] = r_s2.top_in;
            nbhd.in_frame[RING_R]  = 1'b1;
            nbhd.in_frame[RING_BR] = r_s2.bot_in;
            nbhd.in_frame[RING_B]  = r_s2.bot_in;
            nbhd.in_frame[RING_BL] = r_s2.bot_in && r_s2.left_in;
            nbhd.in_frame[RING_L]  = r_s2.left_in;
        end
    end

    rsmw_judge u_judge (
        .i_nbhd      (nbhd),
        .o_sole_peak (sole_peak)
    );

    always_comb begin
        res_word.center_x       = sel2 ? CX_BITS'(r_s2.col)
                                       : CX_BITS'(r_s2.col - COL_BITS'(1));
        res_word.center_y       = CY_BITS'(r_s2.cy);
        res_word.center_present = nbhd.center.present;
        res_word.is_single_max  = sole_peak;
        res_word.last_of_run    = cur_last;
        res_word.last_of_frame  = sel2 && r_s2.last_row;
    end

    // ---------------- control registers ----------------
    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_fire) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end

        n_s2_valid = r_s2_valid;
        if (s1_adv) begin
            n_s2_valid = 1'b1;
        end else if (s2_done) begin
            n_s2_valid = 1'b0;
        end

        n_s2_second = r_s2_second;
        if (s2_done) begin
            n_s2_second = 1'b0;
        end else if (push) begin
            n_s2_second = 1'b1;
        end

        n_out_valid = r_out_valid;
        if (push) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col  <= clamp_last_col(RESET_WIDTH);
            r_height    <= clamp_height(RESET_HEIGHT);
            r_col       <= '0;
            r_row       <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s2_second <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_last_col  <= n_last_col;
            r_height    <= n_height;
            r_col       <= n_col;
            r_row       <= n_row;
            r_s1_valid  <= n_s1_valid;
            r_s2_valid  <= n_s2_valid;
            r_s2_second <= n_s2_second;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ---------------- assertions ----------------
    a_second_needs_emit2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_second |-> (r_s2_valid && r_s2.emit2))
        else $error("second result pending without a last-column center");

    a_no_ram_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && s1_adv) |-> (r_col != r_s1.ctl.col))
        else $error("line RAM read and write-back hit the same column");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= r_last_col)
        else $error("column counter beyond row end");

    a_frame_end_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.last_of_frame) |-> o_out.last_of_run)
        else $error("frame end word not last of its run");

endmodule
`default_nettype wire

FILE: sim/ridge_single_max_window_tb.sv
// Self-checking testbench for the ridge single-maximum window judge.
`timescale 1ns / 1ps
module ridge_single_max_window_tb;
    import rsmw_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 200;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    t_in_word                 in_word   = '0;
    logic                     out_ready = 1'b1;
    logic                     cfg_valid = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
    logic                     in_ready;
    logic                     out_valid;
    t_out_word                out_word;
    logic                     cfg_ready;

    // raster judge state mirrored from the block
    logic [CFG_DATA_BITS-1:0] width_reg;
    logic [CFG_DATA_BITS-1:0] height_reg;
    int                       frame_w;
    int                       frame_h;
    t_cell                    upper_row [MAX_WIDTH];
    t_cell                    middle_row [MAX_WIDTH];
    t_cell [2:0][2:0]         win;
    int                       col_pos;
    int                       row_pos;
    t_out_word                pending_results [$];
    t_out_word                want_word;

    int                       failures    = 0;
    int                       cycle_count = 0;
    logic                     sender_gaps = 1'b0;
    int                       burst_left  = 0;
    logic [15:0]              stall_pattern = 16'hFFFF;
    int                       pattern_age   = 0;

    ridge_single_max_window DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int clamp_dim(logic [CFG_DATA_BITS-1:0] raw, int hi);
        if (raw < MIN_DIM) return MIN_DIM;
        if (raw > hi) return hi;
        return int'(raw);
    endfunction

    function automatic int ring_dx(int i);
        case (i)
            RING_TL, RING_BL, RING_L: return -1;
            RING_T, RING_B:           return 0;
            default:                  return 1;
        endcase
    endfunction

    function automatic int ring_dy(int i);
        case (i)
            RING_TL, RING_T, RING_TR: return -1;
            RING_R, RING_L:           return 0;
            default:                  return 1;
        endcase
    endfunction

    task automatic restart_frame();
        for (int i = 0; i < MAX_WIDTH; i++) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
        win     = '0;
        col_pos = 0;
        row_pos = 0;
        frame_w = clamp_dim(width_reg, MAX_WIDTH);
        frame_h = clamp_dim(height_reg, MAX_HEIGHT);
    endtask

    // g[row][col], row 0 on top, col 0 on the left, g[1][1] the center
    function automatic t_out_word judge_center(t_cell [2:0][2:0] g, int cx, int cy);
        t_out_word            res;
        logic [RING_SIZE-1:0] seen;
        t_cell                nb;
        int                   nx;
        int                   ny;
        int                   runs;
        logic                 single;
        res = '0;
        res.center_x = CX_BITS'(cx);
        res.center_y = CY_BITS'(cy);
        res.center_present = g[1][1].present;
        for (int i = 0; i < RING_SIZE; i++) begin
            nx = cx + ring_dx(i);
            ny = cy + ring_dy(i);
            nb = g[1 + ring_dy(i)][1 + ring_dx(i)];
            seen[i] = nx >= 0 && nx < frame_w && ny >= 0 && ny < frame_h && nb.present;
        end
        runs = 0;
        for (int i = 0; i < RING_SIZE; i++)
            if (seen[i] && !seen[(i + 1) % RING_SIZE]) runs++;
        single = g[1][1].present && runs == TRANS_TARGET;
        for (int i = 0; i < RING_SIZE; i++) begin
            nb = g[1 + ring_dy(i)][1 + ring_dx(i)];
            if (seen[i] && nb.modulus > g[1][1].modulus) single = 1'b0;
        end
        res.is_single_max = single;
        res.last_of_frame = cx == frame_w - 1 && cy == frame_h - 1;
        return res;
    endfunction

    // shift one word into the line rows and window, queue the centers it judges
    task automatic raster_advance(t_in_word w);
        int               c;
        t_cell            cur;
        t_cell            up_cell;
        t_cell            mid_cell;
        t_cell [2:0][2:0] tail_g;
        t_out_word        inner;
        t_out_word        outer;
        logic             has_inner;
        logic             has_outer;
        c = col_pos;
        if (c >= frame_w) c = frame_w - 1;
        cur = '0;
        if (w.command == CMD_POINT && w.point_present && row_pos < frame_h) begin
            cur.present = 1'b1;
            cur.modulus = w.point_modulus;
        end
        up_cell = upper_row[c];
        mid_cell = middle_row[c];
        upper_row[c] = mid_cell;
        middle_row[c] = cur;
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = up_cell;
        win[1][2] = mid_cell;
        win[2][2] = cur;
        has_inner = row_pos >= 1 && c >= 1;
        has_outer = row_pos >= 1 && c == frame_w - 1;
        if (has_inner) begin
            inner = judge_center(win, c - 1, row_pos - 1);
            inner.last_of_run = !has_outer;
            pending_results.push_back(inner);
        end
        if (has_outer) begin
            // right edge center: nothing beyond the last column
            for (int i = 0; i < 3; i++) begin
                tail_g[i][0] = win[i][1];
                tail_g[i][1] = win[i][2];
                tail_g[i][2] = '0;
            end
            outer = judge_center(tail_g, c, row_pos - 1);
            outer.last_of_run = 1'b1;
            pending_results.push_back(outer);
        end
        if (c >= frame_w - 1) begin
            if (row_pos >= frame_h) begin
                restart_frame();
            end else begin
                col_pos = 0;
                row_pos++;
            end
        end else begin
            col_pos = c + 1;
        end
    endtask

    task automatic apply_config(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        if (idx == REG_IMAGE_WIDTH) begin
            width_reg = data;
            restart_frame();
        end else if (idx == REG_IMAGE_HEIGHT) begin
            height_reg = data;
            restart_frame();
        end
    endtask

    task automatic send_word(t_in_word w);
        @(negedge clk);
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        raster_advance(w);
        if (sender_gaps) begin
            if (burst_left == 0) begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge clk);
                burst_left = $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end
    endtask

    // drop valid, drain every pending word, then let the pipeline settle
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        apply_config(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic t_in_word make_word(logic cmd, logic pres, logic [IN_MOD_BITS-1:0] m);
        t_in_word w;
        w.command = cmd;
        w.point_present = pres;
        w.point_modulus = m;
        return w;
    endfunction

    function automatic t_in_word random_point(int pct_present, int span);
        t_in_word w;
        w.command = ($urandom_range(0, 99) < 4) ? CMD_DRAIN : CMD_POINT;
        w.point_present = $urandom_range(0, 99) < pct_present;
        if ($urandom_range(0, 4) == 0)
            w.point_modulus = IN_MOD_BITS'($urandom);
        else
            w.point_modulus = IN_MOD_BITS'($urandom_range(0, span));
        return w;
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] pick_dim();
        if ($urandom_range(0, 9) == 0) return CFG_DATA_BITS'($urandom_range(0, 2));
        return CFG_DATA_BITS'($urandom_range(3, 12));
    endfunction

    task automatic send_points(int n, int pct_present, int span);
        for (int i = 0; i < n; i++) send_word(random_point(pct_present, span));
    endtask

    task automatic compare_field(string name, int want, int got);
        if (want != got) begin
            failures++;
            $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endtask

    // default 256x256 frame straight out of reset: first row and the head of the second
    task automatic test_default_frame();
        sender_gaps = 1'b1;
        send_points(256 + 16, 30, 3);
    endtask

    // smallest frame: a vertical and a horizontal ridge, drain words in and past the frame
    task automatic test_directed_frames();
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(3));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(3));
        send_word(make_word(CMD_POINT, 1'b0, 16'hFFFF));
        send_word(make_word(CMD_POINT, 1'b1, 16'd100));
        send_word(make_word(CMD_POINT, 1'b0, 16'h0000));
        send_word(make_word(CMD_POINT, 1'b0, 16'h0000));
        send_word(make_word(CMD_POINT, 1'b1, 16'd100));
        send_word(make_word(CMD_POINT, 1'b0, 16'hFFFF));
        send_word(make_word(CMD_POINT, 1'b0, 16'h0000));
        send_word(make_word(CMD_POINT, 1'b1, 16'hFFFF));
        send_word(make_word(CMD_POINT, 1'b0, 16'h0000));
        // drain row: a present point here counts as absent
        send_word(make_word(CMD_POINT, 1'b1, 16'hFFFF));
        send_word(make_word(CMD_DRAIN, 1'b1, 16'hFFFF));
        send_word(make_word(CMD_DRAIN, 1'b0, 16'h0000));
        // drain tick inside the frame is an absent point
        send_word(make_word(CMD_DRAIN, 1'b1, 16'hFFFF));
        send_word(make_word(CMD_POINT, 1'b0, 16'h0000));
        send_word(make_word(CMD_POINT, 1'b1, 16'd7));
        send_word(make_word(CMD_POINT, 1'b1, 16'h0000));
        send_word(make_word(CMD_POINT, 1'b1, 16'hFFFF));
        send_word(make_word(CMD_POINT, 1'b1, 16'hFFFF));
        send_word(make_word(CMD_POINT, 1'b0, 16'hFFFF));
        send_word(make_word(CMD_POINT, 1'b0, 16'h0000));
        send_word(make_word(CMD_POINT, 1'b1, 16'h0000));
        send_word(make_word(CMD_DRAIN, 1'b0, 16'h0000));
        send_word(make_word(CMD_DRAIN, 1'b0, 16'h0000));
        send_word(make_word(CMD_POINT, 1'b1, 16'd1234));
    endtask

    // widest clamped row, no centers inside it yet; unused register indexes must
    // leave the frame running
    task automatic test_wide_rows();
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(2047));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(1025));
        sender_gaps = 1'b1;
        send_points(40, 40, 255);
        wait_idle();
        write_reg(CFG_IDX_BITS'(15), CFG_DATA_BITS'(2047));
        write_reg(CFG_IDX_BITS'(2), CFG_DATA_BITS'(0));
        send_points(24, 40, 255);
    endtask

    // tall frame, clamped narrow, run to the end with back-to-back words
    task automatic test_tall_frame();
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(0));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(60));
        sender_gaps = 1'b0;
        send_points(frame_w * (frame_h + 1), 50, 3);
    endtask

    // small random frames, mostly complete, some cut short and restarted
    task automatic test_random_frames();
        int   sent;
        int   n;
        int   pct;
        int   span;
        logic broken;
        sent = 0;
        broken = 1'b1;
        while (sent < RANDOM_ITEMS) begin
            if (broken || $urandom_range(0, 3) != 0) begin
                wait_idle();
                write_reg(REG_IMAGE_WIDTH, pick_dim());
                write_reg(REG_IMAGE_HEIGHT, pick_dim());
            end
            sender_gaps = $urandom_range(0, 3) != 0;
            case ($urandom_range(0, 3))
                0:       pct = 10;
                1:       pct = 35;
                2:       pct = 60;
                default: pct = 90;
            endcase
            case ($urandom_range(0, 2))
                0:       span = 0;
                1:       span = 3;
                default: span = 255;
            endcase
            n = frame_w * (frame_h + 1);
            broken = $urandom_range(0, 5) == 0;
            if (broken) n = $urandom_range(1, n - 1);
            send_points(n, pct, span);
            sent += n;
        end
    endtask

    // receiver: rotate a stall pattern, reload it now and then
    always @(negedge clk) begin
        if (pattern_age == 0) begin
            pattern_age = 40;
            case ($urandom_range(0, 3))
                0:       stall_pattern = 16'hFFFF;
                1:       stall_pattern = 16'hF0F0;
                default: stall_pattern = 16'($urandom) | 16'h0101;
            endcase
        end
        pattern_age--;
        out_ready <= stall_pattern[0];
        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
    end

    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && out_ready) begin
            if (pending_results.size() == 0) begin
                failures++;
                $error("result word with nothing pending: center_x=%0d center_y=%0d",
                       out_word.center_x, out_word.center_y);
            end else begin
                want_word = pending_results.pop_front();
                compare_field("center_x", want_word.center_x, out_word.center_x);
                compare_field("center_y", want_word.center_y, out_word.center_y);
                compare_field("center_present", want_word.center_present,
                              out_word.center_present);
                compare_field("is_single_max", want_word.is_single_max,
                              out_word.is_single_max);
                compare_field("last_of_run", want_word.last_of_run, out_word.last_of_run);
                compare_field("last_of_frame", want_word.last_of_frame,
                              out_word.last_of_frame);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ridge_single_max_window_tb: FAIL");
            $finish;
        end
    end

    initial begin
        width_reg  = RESET_WIDTH;
        height_reg = RESET_HEIGHT;
        restart_frame();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_default_frame();
        test_directed_frames();
        test_wide_rows();
        test_tall_frame();
        test_random_frames();
        wait_idle();
        if (failures == 0)
            $display("ridge_single_max_window_tb: PASS");
        else
            $display("ridge_single_max_window_tb: FAIL");
        $finish;
    end

endmodule
